[rtl/core/frc_pkg.sv]
// Shared types, codes and reset values of the fragment reassembly checker.
package frc_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 24;
    localparam int CFG_WIDTH = 24;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [7:0] MORE_TYPE_RESET = 8'd2;
    localparam logic [7:0] END_TYPE_RESET = 8'd3;
    localparam logic [23:0] MAX_BYTES_RESET = 24'd1048576;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_MORE_TYPE = 2'd0,
        REG_END_TYPE  = 2'd1,
        REG_MAX_BYTES = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        STATUS_NONE      = 2'd0,
        STATUS_COMPLETE  = 2'd1,
        STATUS_DISCARDED = 2'd2,
        STATUS_ERROR     = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]  more_code;
        logic [7:0]  end_code;
        logic [23:0] max_bytes;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_first;
        logic       frame_last;
        logic       frame_empty;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       msg_first;
        status_t    status;
    } result_t;

endpackage

[rtl/core/fragment_reassembly_checker_unit.sv]
// Fragment reassembly checker: top level with input and result registers.
//
// Takes one frame byte per item and returns one result item per input item, at up to one
// item per clock while the output side keeps up. An accepted item waits in the input
// register, is classified and updates the reassembly state as it moves into the result
// register. The result register decouples the sides: a new item is taken while a finished
// result waits, and only a full pipeline with the output stalled holds off input.
// Configuration registers take effect on the next item; they must be written while no
// item is in flight, and the block itself does not enforce this.
module fragment_reassembly_checker_unit #(
    parameter int COUNT_WIDTH = frc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [7:0] data_byte
    input  logic                                 s_tlast,   // frame_last
    input  logic [1:0]                           s_tuser,   // [0] frame_first, [1] frame_empty
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [7:0]                           m_tdata,   // [7:0] out_byte
    output logic [3:0]                           m_tuser,   // [0] out_valid, [1] msg_first,
                                                            // [3:2] status
    input  logic                                 cfg_we,
    input  logic [frc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [frc_pkg::CFG_WIDTH-1:0]        cfg_data
);

    frc_pkg::cfg_t    cfg;
    frc_pkg::item_t   in_item_reg;
    logic             in_valid_reg;
    frc_pkg::result_t result;
    frc_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    frc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    frc_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.data_byte   <= s_tdata;
            in_item_reg.frame_first <= s_tuser[0];
            in_item_reg.frame_last  <= s_tlast;
            in_item_reg.frame_empty <= s_tuser[1];
        end
        if (advance)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.out_byte;
    assign m_tuser  = {out_reg.status, out_reg.msg_first, out_reg.out_valid};

`ifndef SYNTHESIS
    a_first_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("msg_first without out_valid");

    a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
        else $error("out_byte set on an invalid byte");

    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && m_tvalid && !m_tready)
        else $error("input held off with room in the pipeline");

    a_empty_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.frame_empty |=> m_tvalid && m_tuser == 4'd0 && m_tdata == 8'd0)
        else $error("empty frame item gave a non-zero result");
`endif

endmodule

[rtl/core/frc_cfg.sv]
// Configuration registers of the fragment reassembly checker.
module frc_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [frc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [frc_pkg::CFG_WIDTH-1:0]        cfg_data,
    output frc_pkg::cfg_t                        cfg
);

    frc_pkg::cfg_t cfg_reg;
    frc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (frc_pkg::reg_index_t'(cfg_index))
                frc_pkg::REG_MORE_TYPE: cfg_next.more_code = cfg_data[7:0];
                frc_pkg::REG_END_TYPE:  cfg_next.end_code = cfg_data[7:0];
                frc_pkg::REG_MAX_BYTES: cfg_next.max_bytes = cfg_data[23:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.more_code <= frc_pkg::MORE_TYPE_RESET;
            cfg_reg.end_code  <= frc_pkg::END_TYPE_RESET;
            cfg_reg.max_bytes <= frc_pkg::MAX_BYTES_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/frc_step.sv]
// Frame classification, reassembly state and size check for one item.
module frc_step #(
    parameter int COUNT_WIDTH = frc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  frc_pkg::item_t   item,
    input  frc_pkg::cfg_t    cfg,
    output frc_pkg::result_t result
);

    localparam int CMP_WIDTH = (COUNT_WIDTH > 24) ? COUNT_WIDTH : 24;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_TYPE = 3'd1,
        MODE_FRAG = 3'd2,
        MODE_PASS = 3'd3,
        MODE_SKIP = 3'd4
    } mode_t;

    mode_t                  mode_reg, mode_next;
    logic                   reasm_reg, reasm_next;
    logic                   end_open_reg, end_open_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [7:0]             type_reg, type_next;

    logic                   nested;
    logic                   over_limit;
    logic                   valid;
    logic                   first;
    frc_pkg::status_t       status;

    assign nested = (type_reg == cfg.more_code) || (type_reg == cfg.end_code);
    assign over_limit = (CMP_WIDTH'(count_reg) >= CMP_WIDTH'(cfg.max_bytes)) || (&count_reg);

    always_comb
    begin
        mode_next     = mode_reg;
        reasm_next    = reasm_reg;
        end_open_next = end_open_reg;
        count_next    = count_reg;
        type_next     = type_reg;
        valid         = 1'b0;
        first         = 1'b0;
        status        = frc_pkg::STATUS_NONE;
        if (!item.frame_empty)
        begin
            if (item.frame_first)
            begin
                end_open_next = 1'b0;
                if (item.data_byte == cfg.more_code)
                begin
                    if (reasm_reg)
                        mode_next = MODE_FRAG;
                    else
                        mode_next = item.frame_last ? MODE_IDLE : MODE_TYPE;
                end
                else if (item.data_byte == cfg.end_code)
                begin
                    if (reasm_reg)
                    begin
                        end_open_next = 1'b1;
                        mode_next = MODE_FRAG;
                        if (item.frame_last)
                        begin
                            reasm_next = 1'b0;
                            end_open_next = 1'b0;
                            status = nested ? frc_pkg::STATUS_ERROR : frc_pkg::STATUS_COMPLETE;
                        end
                    end
                    else
                    begin
                        status = frc_pkg::STATUS_ERROR;
                        mode_next = MODE_SKIP;
                    end
                end
                else if (reasm_reg)
                begin
                    reasm_next = 1'b0;
                    status = frc_pkg::STATUS_ERROR;
                    mode_next = MODE_SKIP;
                end
                else
                begin
                    valid = 1'b1;
                    first = 1'b1;
                    mode_next = MODE_PASS;
                    if (item.frame_last)
                        status = frc_pkg::STATUS_COMPLETE;
                end
            end
            else
            begin
                unique case (mode_reg)
                    MODE_IDLE:
                    begin
                        mode_next = mode_reg;
                    end
                    MODE_TYPE:
                    begin
                        valid = 1'b1;
                        first = 1'b1;
                        type_next = item.data_byte;
                        count_next = '0;
                        reasm_next = 1'b1;
                        mode_next = MODE_FRAG;
                    end
                    MODE_FRAG:
                    begin
                        if (over_limit)
                        begin
                            status = frc_pkg::STATUS_DISCARDED;
                            reasm_next = 1'b0;
                            end_open_next = 1'b0;
                            mode_next = MODE_SKIP;
                        end
                        else
                        begin
                            count_next = count_reg + COUNT_WIDTH'(1);
                            valid = 1'b1;
                            if (item.frame_last && end_open_reg)
                            begin
                                reasm_next = 1'b0;
                                end_open_next = 1'b0;
                                status = nested ? frc_pkg::STATUS_ERROR
                                                : frc_pkg::STATUS_COMPLETE;
                            end
                        end
                    end
                    MODE_PASS:
                    begin
                        valid = 1'b1;
                        if (item.frame_last)
                            status = frc_pkg::STATUS_COMPLETE;
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
            if (item.frame_last)
                mode_next = MODE_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            reasm_reg    <= 1'b0;
            end_open_reg <= 1'b0;
            count_reg    <= '0;
            type_reg     <= '0;
        end
        else if (advance)
        begin
            mode_reg     <= mode_next;
            reasm_reg    <= reasm_next;
            end_open_reg <= end_open_next;
            count_reg    <= count_next;
            type_reg     <= type_next;
        end
    end

    assign result.out_byte  = valid ? item.data_byte : 8'd0;
    assign result.out_valid = valid;
    assign result.msg_first = first;
    assign result.status    = status;

endmodule
